>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the MD5 engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> sv/md5he_pkg.sv
// ----------------------------------------------------------------------------
// MD5 engine package
// Types, constants and step tables shared by the MD5 engine modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package md5he_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS = 6'd56;
  localparam logic [5:0]  LAST_POS = 6'd63;

  typedef enum logic [3:0] {
    S_IDLE, S_BYTE, S_PAD, S_ZERO, S_LEN, S_COMP, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    C_IDLE, C_RUN, C_ADD
  } core_state_t;

  typedef struct packed {
    logic start;
    logic init;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
  } core_stat_t;

  function automatic logic [31:0] step_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] step_rot(input logic [3:0] sel);
    logic [4:0] r;
    unique case (sel)
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/md5he_core.sv
// ----------------------------------------------------------------------------
// MD5 compression core
// Runs the 64 MD5 steps at one step per cycle and folds the result into the
// chaining values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module md5he_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire md5he_pkg::core_ctrl_t  ctrl,
  input  wire logic [31:0]            word,
  output logic [3:0]                  word_idx,
  output md5he_pkg::core_stat_t       stat,
  output logic [127:0]                chain
);

  md5he_pkg::core_state_t state, state_next;
  logic [5:0]  step;
  logic [31:0] a, b, c, d;
  logic [31:0] h0, h1, h2, h3;
  logic [31:0] f, sum;
  logic [63:0] rot_wide;
  logic [1:0]  rnd;

  assign rnd = step[5:4];

  always_comb begin
    unique case (rnd)
      2'd0: begin
        f = (b & c) | (~b & d);
        word_idx = step[3:0];
      end
      2'd1: begin
        f = (b & d) | (c & ~d);
        word_idx = 4'(5 * step[3:0] + 1);
      end
      2'd2: begin
        f = b ^ c ^ d;
        word_idx = 4'(3 * step[3:0] + 5);
      end
      default: begin
        f = c ^ (b | ~d);
        word_idx = 4'(7 * step[3:0]);
      end
    endcase
    sum = a + f + md5he_pkg::step_k(step) + word;
    rot_wide = {sum, sum} << md5he_pkg::step_rot({rnd, step[1:0]});
  end

  always_comb begin
    state_next = state;
    unique case (state)
      md5he_pkg::C_IDLE: if (ctrl.start) state_next = md5he_pkg::C_RUN;
      md5he_pkg::C_RUN:  if (step == 6'd63) state_next = md5he_pkg::C_ADD;
      default:           state_next = md5he_pkg::C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= md5he_pkg::C_IDLE;
      step <= '0;
      h0 <= md5he_pkg::IV_A;
      h1 <= md5he_pkg::IV_B;
      h2 <= md5he_pkg::IV_C;
      h3 <= md5he_pkg::IV_D;
    end else begin
      state <= state_next;
      if (ctrl.init) begin
        h0 <= md5he_pkg::IV_A;
        h1 <= md5he_pkg::IV_B;
        h2 <= md5he_pkg::IV_C;
        h3 <= md5he_pkg::IV_D;
      end
      unique case (state)
        md5he_pkg::C_IDLE: begin
          step <= '0;
          a <= h0;
          b <= h1;
          c <= h2;
          d <= h3;
        end
        md5he_pkg::C_RUN: begin
          step <= step + 6'd1;
          a <= d;
          d <= c;
          c <= b;
          b <= b + rot_wide[63:32];
        end
        default: begin
          h0 <= h0 + a;
          h1 <= h1 + b;
          h2 <= h2 + c;
          h3 <= h3 + d;
        end
      endcase
    end
  end

  assign stat.busy = (state != md5he_pkg::C_IDLE);
  assign chain = {h3, h2, h1, h0};

  `ASSERT_RST(a_add_after_last_step, clk, rst,
    (state == md5he_pkg::C_ADD) |-> ($past(step) == 6'd63), "add without full run")
  `ASSERT_RST(a_start_only_idle, clk, rst,
    (ctrl.start && state == md5he_pkg::C_IDLE) |=> (state == md5he_pkg::C_RUN && step == 6'd0),
    "start not taken")
  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == md5he_pkg::C_IDLE), "core not idle")

endmodule
`default_nettype wire

>>> sv/md5_hash_engine_top.sv
// MD5 engine: bytes enter the block buffer one per cycle, pausing while a full
// 64-byte block is compressed; a word of n bytes passes the accept step, n byte
// writes and a step back to idle. Each full block runs through the compression
// core (64 steps at one per cycle, the chain add and the hand back). The last
// transaction also writes padding one byte per cycle, with the same pauses, and
// runs one or two more compressions before the digest appears. in_stall stays high while busy.
// ----------------------------------------------------------------------------
// MD5 engine top level
// Byte packer, padding sequencer and digest output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module md5_hash_engine_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      digest_low,
  output logic [63:0]      digest_high
);

  md5he_pkg::state_t state, state_next, ret_state;
  md5he_pkg::core_ctrl_t ctrl;
  md5he_pkg::core_stat_t stat;
  logic [31:0]  block_words [16];
  logic [31:0]  word;
  logic [2:0]   cnt;
  logic         fin;
  logic [63:0]  bit_length;
  logic [63:0]  len;
  logic [5:0]   pad_pos;
  logic [5:0]   pos;
  logic [3:0]   word_idx;
  logic [127:0] chain;
  logic         out_free;

  assign pos = bit_length[8:3];
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != md5he_pkg::S_IDLE);

  md5he_core u_core (
    .clk(clk), .rst(rst), .ctrl(ctrl), .word(block_words[word_idx]),
    .word_idx(word_idx), .stat(stat), .chain(chain)
  );

  always_comb begin
    state_next = state;
    ctrl.start = 1'b0;
    ctrl.init = 1'b0;
    unique case (state)
      md5he_pkg::S_IDLE: if (in_valid) state_next = md5he_pkg::S_BYTE;
      md5he_pkg::S_BYTE: begin
        if (cnt != 3'd0) begin
          if (pos == md5he_pkg::LAST_POS) begin
            state_next = md5he_pkg::S_COMP;
            ctrl.start = 1'b1;
          end
        end else if (fin) begin
          state_next = md5he_pkg::S_PAD;
        end else begin
          state_next = md5he_pkg::S_IDLE;
        end
      end
      md5he_pkg::S_PAD: begin
        if (pos == md5he_pkg::LAST_POS) begin
          state_next = md5he_pkg::S_COMP;
          ctrl.start = 1'b1;
        end else if (pos + 6'd1 == md5he_pkg::LEN_POS) begin
          state_next = md5he_pkg::S_LEN;
        end else begin
          state_next = md5he_pkg::S_ZERO;
        end
      end
      md5he_pkg::S_ZERO: begin
        if (pad_pos == md5he_pkg::LEN_POS) begin
          state_next = md5he_pkg::S_LEN;
        end else if (pad_pos == md5he_pkg::LAST_POS) begin
          state_next = md5he_pkg::S_COMP;
          ctrl.start = 1'b1;
        end
      end
      md5he_pkg::S_LEN: begin
        state_next = md5he_pkg::S_COMP;
        ctrl.start = 1'b1;
      end
      md5he_pkg::S_COMP: if (!stat.busy) state_next = ret_state;
      md5he_pkg::S_DONE: begin
        if (out_free) begin
          ctrl.init = 1'b1;
          state_next = md5he_pkg::S_IDLE;
        end
      end
      default: state_next = md5he_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= md5he_pkg::S_IDLE;
      ret_state <= md5he_pkg::S_IDLE;
      bit_length <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == md5he_pkg::S_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        md5he_pkg::S_IDLE: begin
          word <= data_word;
          cnt <= byte_count[2] ? 3'd4 : byte_count;
          fin <= last;
        end
        md5he_pkg::S_BYTE: begin
          ret_state <= md5he_pkg::S_BYTE;
          if (cnt != 3'd0) begin
            block_words[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= word[7:0];
            word <= word >> 8;
            cnt <= cnt - 3'd1;
            bit_length <= bit_length + 64'd8;
          end
        end
        md5he_pkg::S_PAD: begin
          block_words[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= md5he_pkg::PAD_BYTE;
          len <= bit_length;
          pad_pos <= pos + 6'd1;
          ret_state <= md5he_pkg::S_ZERO;
        end
        md5he_pkg::S_ZERO: begin
          ret_state <= md5he_pkg::S_ZERO;
          if (pad_pos != md5he_pkg::LEN_POS) begin
            block_words[pad_pos[5:2]][{pad_pos[1:0], 3'b000} +: 8] <= 8'h00;
            pad_pos <= pad_pos + 6'd1;
          end
        end
        md5he_pkg::S_LEN: begin
          block_words[14] <= len[31:0];
          block_words[15] <= len[63:32];
          ret_state <= md5he_pkg::S_DONE;
        end
        md5he_pkg::S_DONE: begin
          if (out_free) begin
            digest_low <= chain[63:0];
            digest_high <= chain[127:64];
            bit_length <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_RST(a_core_busy_in_comp, clk, rst,
    stat.busy |-> (state == md5he_pkg::S_COMP), "core runs outside compression")
  `ASSERT_RST(a_result_from_done, clk, rst,
    $rose(out_valid) |-> ($past(state) == md5he_pkg::S_DONE), "digest without finish")
  `ASSERT_RST(a_len_cleared, clk, rst,
    ($past(state) == md5he_pkg::S_DONE && state == md5he_pkg::S_IDLE) |-> (bit_length == 64'd0),
    "length not cleared")
  `ASSERT_ALWAYS(a_reset_no_result, clk, rst |=> !out_valid, "result after reset")

endmodule
`default_nettype wire
